/* rtl/cfa_pkg.sv */
// Package for the contiguous fit allocator.
// Holds opcodes, status codes, fit policies, register indexes and the sequencer states.
// No dependencies.
package cfa_pkg;

   localparam logic [1:0] OP_REQUEST = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_FIND    = 2'd2;

   localparam logic [1:0] FIT_BEST  = 2'd0;
   localparam logic [1:0] FIT_FIRST = 2'd1;
   localparam logic [1:0] FIT_NEXT  = 2'd2;
   localparam logic [1:0] FIT_WORST = 2'd3;

   localparam logic REG_FIT_MODE   = 1'b0;
   localparam logic REG_TOTAL_SIZE = 1'b1;

   localparam logic [2:0] RS_ALLOCATED   = 3'd0;
   localparam logic [2:0] RS_REQ_FAILED  = 3'd1;
   localparam logic [2:0] RS_FREED       = 3'd2;
   localparam logic [2:0] RS_REL_FAILED  = 3'd3;
   localparam logic [2:0] RS_FOUND       = 3'd4;
   localparam logic [2:0] RS_NOT_FOUND   = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT_UP,
      ST_SHIFT_DN,
      ST_PUT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic take;
      logic stop;
   } fit_flags_type;

endpackage

/* rtl/cfa_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module cfa_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/cfa_fit.sv */
// Placement decision for one hole under the selected fit policy.
// Depends on cfa_pkg.
module cfa_fit
   import cfa_pkg::*;
#(
   parameter int AW = 16
) (
   input  logic [AW:0]   hole_start,
   input  logic [AW-1:0] hole_limit,
   input  logic [AW-1:0] req_size,
   input  logic [AW-1:0] rov,
   input  logic [1:0]    fit_mode,
   input  logic          rov_pass,
   input  logic          is_end,
   input  logic          found,
   input  logic [AW-1:0] best,
   output fit_flags_type flags,
   output logic [AW:0]   at,
   output logic [AW-1:0] hole_size
);
   logic [AW:0] lim_x;
   logic [AW:0] rov_x;
   logic [AW:0] cand;
   logic [AW:0] diff;
   logic        fits;
   logic        rov_ok;

   assign lim_x     = {1'b0, hole_limit};
   assign rov_x     = {1'b0, rov};
   assign hole_size = (lim_x > hole_start) ? AW'(lim_x - hole_start) : '0;
   assign fits      = hole_size >= req_size;
   assign cand      = (hole_start > rov_x) ? hole_start : rov_x;
   assign diff      = lim_x - cand;
   assign rov_ok    = (lim_x > rov_x) && (lim_x >= cand) && (diff >= {1'b0, req_size});

   always_comb begin
      flags.take = 1'b0;
      flags.stop = 1'b0;
      at         = hole_start;
      if (rov_pass) begin
         flags.take = rov_ok;
         flags.stop = rov_ok;
         at         = cand;
      end else begin
         case (fit_mode)
            FIT_FIRST, FIT_NEXT: begin
               flags.take = fits;
               flags.stop = fits;
            end
            FIT_BEST: begin
               flags.take = fits && (!found || (is_end ? hole_size <= best : hole_size < best));
            end
            default: begin
               flags.take = fits && (!found || (is_end ? hole_size >= best : hole_size > best));
            end
         endcase
      end
   end
endmodule

/* rtl/contiguous_fit_allocator.sv */
// Contiguous fit allocator: sorted block table in one RAM, scanned and shifted in place.
// A request scans up to count+1 holes at one RAM read per cycle, then shifts the entries
// above the insertion point one per cycle; next fit may scan twice.
// Release and find scan up to count entries; release then shifts the rest down.
// Synchronous active-high reset empties the table; RAM contents need no clearing.
// Depends on cfa_pkg, cfa_ram and cfa_fit.
module contiguous_fit_allocator
   import cfa_pkg::*;
#(
   parameter int MAX_BLOCKS = 32,
   parameter int ADDR_WIDTH = 16,
   parameter int ID_WIDTH   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_mode,
   input  logic [ID_WIDTH-1:0]   req_block_id,
   input  logic [ADDR_WIDTH-1:0] req_request_size,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_status,
   output logic [ADDR_WIDTH-1:0] rsp_block_start,
   output logic [ADDR_WIDTH-1:0] rsp_block_size,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [ADDR_WIDTH-1:0] csr_wdata
);
   localparam int AW = ADDR_WIDTH;
   localparam int IDW = ID_WIDTH;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int EW = IDW + 2 * AW;

   state_type state_ff, state_in;

   logic [1:0]    fit_mode_ff;
   logic [AW-1:0] total_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] rov_ff, rov_in;

   logic [1:0]     op_ff, op_in;
   logic [IDW-1:0] id_ff, id_in;
   logic [AW-1:0]  rq_ff, rq_in;

   logic [CW:0]   iss_ff, iss_in;
   logic          ev_vld_ff, ev_vld_in;
   logic [CW-1:0] ev_g_ff, ev_g_in;
   logic [AW:0]   prev_end_ff, prev_end_in;
   logic          found_ff, found_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [AW:0]   at_ff, at_in;
   logic [AW-1:0] best_ff, best_in;
   logic          pass_ff, pass_in;
   logic [CW-1:0] sh_ff, sh_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] pend_addr_ff, pend_addr_in;

   logic [2:0]    res_status_ff, res_status_in;
   logic [AW-1:0] res_start_ff, res_start_in;
   logic [AW-1:0] res_size_ff, res_size_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [AW-1:0] rsp_start_ff, rsp_start_in;
   logic [AW-1:0] rsp_size_ff, rsp_size_in;

   logic          ram_we, ram_re;
   logic [IW-1:0] ram_wa, ram_ra;
   logic [EW-1:0] ram_wd, ram_rd;

   logic [IDW-1:0] e_id;
   logic [AW-1:0]  e_start, e_size;
   logic           accept, is_end, lookup, match, iss_go, scan_end, req_found;
   logic           up_go, dn_go, rsp_free;
   logic [AW-1:0]  hole_lim, hole_sz;
   logic [AW:0]    fit_at;
   fit_flags_type  fit_flags;

   assign e_id      = ram_rd[EW-1 -: IDW];
   assign e_start   = ram_rd[2*AW-1 -: AW];
   assign e_size    = ram_rd[AW-1:0];
   assign accept    = req_valid && req_ready;
   assign lookup    = op_ff != OP_REQUEST;
   assign is_end    = ev_g_ff == cnt_ff;
   assign match     = !is_end && (e_id == id_ff);
   assign iss_go    = (state_ff == ST_SCAN) && (iss_ff <= {1'b0, cnt_ff});
   assign hole_lim  = is_end ? total_ff : e_start;
   assign scan_end  = (state_ff == ST_SCAN) && ev_vld_ff &&
                      (lookup ? (match || is_end) : (fit_flags.stop || is_end));
   assign req_found = found_ff || fit_flags.take;
   assign up_go     = sh_ff > pos_ff;
   assign dn_go     = (sh_ff + CW'(1)) < cnt_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   cfa_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   cfa_fit #(.AW(AW)) u_fit (
      .hole_start (prev_end_ff),
      .hole_limit (hole_lim),
      .req_size   (rq_ff),
      .rov        (rov_ff),
      .fit_mode   (fit_mode_ff),
      .rov_pass   (pass_ff),
      .is_end     (is_end),
      .found      (found_ff),
      .best       (best_ff),
      .flags      (fit_flags),
      .at         (fit_at),
      .hole_size  (hole_sz)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == OP_RELEASE || req_mode == OP_FIND) begin
                  state_in = ST_SCAN;
               end else if (req_mode == OP_REQUEST && cnt_ff != CW'(MAX_BLOCKS)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               if (lookup) begin
                  state_in = (match && op_ff == OP_RELEASE) ? ST_SHIFT_DN : ST_DONE;
               end else if (req_found) begin
                  state_in = ST_SHIFT_UP;
               end else if (!pass_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SHIFT_UP: begin
            if (!up_go) begin
               state_in = ST_PUT;
            end
         end
         ST_SHIFT_DN: begin
            if (!dn_go) begin
               state_in = ST_DONE;
            end
         end
         ST_PUT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = state_ff == ST_IDLE;
      ram_re    = 1'b0;
      ram_ra    = '0;
      ram_we    = 1'b0;
      ram_wa    = pend_addr_ff;
      ram_wd    = ram_rd;
      unique case (state_ff)
         ST_SCAN: begin
            ram_re = iss_go && (iss_ff < {1'b0, cnt_ff});
            ram_ra = iss_ff[IW-1:0];
         end
         ST_SHIFT_UP: begin
            ram_re = up_go;
            ram_ra = IW'(sh_ff - CW'(1));
            ram_we = pend_ff;
         end
         ST_SHIFT_DN: begin
            ram_re = dn_go;
            ram_ra = IW'(sh_ff + CW'(1));
            ram_we = pend_ff;
         end
         ST_PUT: begin
            ram_we = 1'b1;
            ram_wa = pos_ff[IW-1:0];
            ram_wd = {id_ff, at_ff[AW-1:0], rq_ff};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      op_in         = op_ff;
      id_in         = id_ff;
      rq_in         = rq_ff;
      cnt_in        = cnt_ff;
      rov_in        = rov_ff;
      iss_in        = iss_ff;
      ev_vld_in     = 1'b0;
      ev_g_in       = ev_g_ff;
      prev_end_in   = prev_end_ff;
      found_in      = found_ff;
      pos_in        = pos_ff;
      at_in         = at_ff;
      best_in       = best_ff;
      pass_in       = pass_ff;
      sh_in         = sh_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_size_in   = res_size_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_size_in   = rsp_size_ff;
      case (state_ff)
         ST_IDLE: begin
            op_in       = req_mode;
            id_in       = req_block_id;
            rq_in       = req_request_size;
            iss_in      = '0;
            prev_end_in = '0;
            found_in    = 1'b0;
            pass_in     = (req_mode == OP_REQUEST) && (fit_mode_ff == FIT_NEXT);
            if (req_mode == OP_REQUEST) begin
               res_status_in = RS_REQ_FAILED;
               res_start_in  = '0;
               res_size_in   = req_request_size;
            end else begin
               res_status_in = (req_mode == OP_RELEASE) ? RS_REL_FAILED : RS_NOT_FOUND;
               res_start_in  = '0;
               res_size_in   = '0;
            end
         end
         ST_SCAN: begin
            if (iss_go) begin
               iss_in    = iss_ff + (CW+1)'(1);
               ev_vld_in = 1'b1;
               ev_g_in   = iss_ff[CW-1:0];
            end
            if (ev_vld_ff) begin
               if (!is_end) begin
                  prev_end_in = {1'b0, e_start} + {1'b0, e_size};
               end
               if (!lookup && fit_flags.take) begin
                  found_in = 1'b1;
                  pos_in   = ev_g_ff;
                  at_in    = fit_at;
                  best_in  = hole_sz;
               end
            end
            if (scan_end) begin
               ev_vld_in = 1'b0;
               if (lookup) begin
                  if (match) begin
                     res_status_in = (op_ff == OP_RELEASE) ? RS_FREED : RS_FOUND;
                     res_start_in  = e_start;
                     res_size_in   = e_size;
                     sh_in         = ev_g_ff;
                  end
               end else if (req_found) begin
                  sh_in = cnt_ff;
               end else if (pass_ff) begin
                  pass_in     = 1'b0;
                  iss_in      = '0;
                  prev_end_in = '0;
               end
            end
         end
         ST_SHIFT_UP: begin
            if (up_go) begin
               pend_in      = 1'b1;
               pend_addr_in = sh_ff[IW-1:0];
               sh_in        = sh_ff - CW'(1);
            end
         end
         ST_SHIFT_DN: begin
            if (dn_go) begin
               pend_in      = 1'b1;
               pend_addr_in = sh_ff[IW-1:0];
               sh_in        = sh_ff + CW'(1);
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         ST_PUT: begin
            cnt_in        = cnt_ff + CW'(1);
            res_status_in = RS_ALLOCATED;
            res_start_in  = at_ff[AW-1:0];
            res_size_in   = rq_ff;
            if (fit_mode_ff == FIT_NEXT) begin
               rov_in = AW'(at_ff + {1'b0, rq_ff});
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               rsp_size_in   = res_size_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fit_mode_ff  <= FIT_BEST;
         total_ff     <= '1;
         cnt_ff       <= '0;
         rov_ff       <= '0;
         ev_vld_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rov_ff       <= rov_in;
         ev_vld_ff    <= ev_vld_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            if (csr_index == REG_FIT_MODE) begin
               fit_mode_ff <= csr_wdata[1:0];
            end else begin
               total_ff <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      rq_ff         <= rq_in;
      iss_ff        <= iss_in;
      ev_g_ff       <= ev_g_in;
      prev_end_ff   <= prev_end_in;
      found_ff      <= found_in;
      pos_ff        <= pos_in;
      at_ff         <= at_in;
      best_ff       <= best_in;
      pass_ff       <= pass_in;
      sh_ff         <= sh_in;
      pend_addr_ff  <= pend_addr_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_size_ff   <= res_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_block_start = rsp_start_ff;
   assign rsp_block_size  = rsp_size_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_BLOCKS))
      else $error("entry count exceeds table depth");

   a_put_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PUT |-> cnt_ff < CW'(MAX_BLOCKS))
      else $error("insert into a full table");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request accepted while still busy");

   a_shift_no_collide: assert property (@(posedge clock) disable iff (reset)
      ram_we && ram_re |-> ram_wa != ram_ra)
      else $error("shift reads the entry it writes");
endmodule

/* dv/contiguous_fit_allocator_test.sv */
// Self-checking testbench for the contiguous fit allocator: directed rows, then random
// requests, releases and finds under every fit policy and several managed sizes.
// Depends on cfa_pkg and the contiguous_fit_allocator RTL.
`timescale 1ns / 1ps
module contiguous_fit_allocator_test;
   import cfa_pkg::*;

   localparam int TABLE_DEPTH = 32;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [2:0]  status;
      logic [15:0] start;
      logic [15:0] size;
   } alloc_result_type;

   typedef struct {
      logic [1:0]       mode;
      logic [15:0]      id;
      logic [15:0]      size;
      bit               typed;
      alloc_result_type result;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_mode;
   logic [15:0] req_block_id;
   logic [15:0] req_request_size;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_block_start;
   logic [15:0] rsp_block_size;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   bit               drv_typed;
   alloc_result_type drv_result;

   alloc_result_type expected_results[$];
   stim_row_type     dir_rows[$];
   int               error_count = 0;
   int               cycle_count = 0;
   int               send_idle_pct;
   int               recv_stall_pct;

   int       blk_id[TABLE_DEPTH];
   int       blk_start[TABLE_DEPTH];
   int       blk_size[TABLE_DEPTH];
   int       blk_count;
   int       rover;
   logic [1:0] cur_fit;
   int       cur_total;

   contiguous_fit_allocator u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_block_id(req_block_id), .req_request_size(req_request_size),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_block_start(rsp_block_start), .rsp_block_size(rsp_block_size),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int gap_start(int g);
      if (g == 0) return 0;
      return blk_start[g-1] + blk_size[g-1];
   endfunction

   function automatic int gap_limit(int g);
      if (g >= blk_count) return cur_total;
      return blk_start[g];
   endfunction

   function automatic alloc_result_type place_block(logic [1:0] m, logic [15:0] id,
                                                    logic [15:0] req);
      alloc_result_type r;
      int k, g, i, pos, at, best, s, l, c, hs;
      bit found, take;
      r = '{RS_NOT_FOUND, 16'd0, 16'd0};
      if (m == OP_RELEASE || m == OP_FIND) begin
         k = -1;
         for (i = blk_count - 1; i >= 0; i--)
            if (blk_id[i] == int'(id)) k = i;
         if (k < 0) begin
            r.status = (m == OP_RELEASE) ? RS_REL_FAILED : RS_NOT_FOUND;
            return r;
         end
         r = '{(m == OP_RELEASE) ? RS_FREED : RS_FOUND, blk_start[k][15:0],
               blk_size[k][15:0]};
         if (m == OP_RELEASE) begin
            for (i = k; i + 1 < blk_count; i++) begin
               blk_id[i] = blk_id[i+1];
               blk_start[i] = blk_start[i+1];
               blk_size[i] = blk_size[i+1];
            end
            blk_count--;
         end
         return r;
      end
      if (m == OP_UNUSED) return r;
      found = 0; pos = 0; at = 0; best = 0;
      if (blk_count < TABLE_DEPTH) begin
         if (cur_fit == FIT_FIRST || cur_fit == FIT_NEXT) begin
            if (cur_fit == FIT_NEXT)
               for (g = 0; g <= blk_count && !found; g++) begin
                  s = gap_start(g);
                  l = gap_limit(g);
                  c = (s > rover) ? s : rover;
                  if (l > rover && l >= c && l - c >= int'(req)) begin
                     found = 1; pos = g; at = c;
                  end
               end
            for (g = 0; g <= blk_count && !found; g++) begin
               s = gap_start(g);
               l = gap_limit(g);
               hs = (l > s) ? l - s : 0;
               if (hs >= int'(req)) begin
                  found = 1; pos = g; at = s;
               end
            end
         end else begin
            for (g = 0; g <= blk_count; g++) begin
               s = gap_start(g);
               l = gap_limit(g);
               hs = (l > s) ? l - s : 0;
               if (hs >= int'(req)) begin
                  if (!found) take = 1;
                  else if (cur_fit == FIT_BEST)
                     take = (g == blk_count) ? hs <= best : hs < best;
                  else
                     take = (g == blk_count) ? hs >= best : hs > best;
                  if (take) begin
                     found = 1; pos = g; best = hs; at = s;
                  end
               end
            end
         end
      end
      if (!found) return '{RS_REQ_FAILED, 16'd0, req};
      for (i = blk_count; i > pos; i--) begin
         blk_id[i] = blk_id[i-1];
         blk_start[i] = blk_start[i-1];
         blk_size[i] = blk_size[i-1];
      end
      blk_id[pos] = int'(id);
      blk_start[pos] = at & 16'hFFFF;
      blk_size[pos] = int'(req);
      blk_count++;
      if (cur_fit == FIT_NEXT) rover = (at + int'(req)) & 16'hFFFF;
      return '{RS_ALLOCATED, at[15:0], req};
   endfunction

   task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
      $display("mismatch in %s: got %0d, expected %0d at cycle %0d", field, got, want,
               cycle_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      alloc_result_type pred, want;
      cycle_count <= cycle_count + 1;
      if (!reset && req_valid && req_ready) begin
         pred = place_block(req_mode, req_block_id, req_request_size);
         expected_results.push_back(drv_typed ? drv_result : pred);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("unexpected result at cycle %0d", cycle_count);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_block_start !== want.start)
               report_mismatch("block_start", rsp_block_start, want.start);
            if (rsp_block_size !== want.size)
               report_mismatch("block_size", rsp_block_size, want.size);
         end
      end
      rsp_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout");
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic send_request(stim_row_type row);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_mode <= row.mode;
      req_block_id <= row.id;
      req_request_size <= row.size;
      drv_typed <= row.typed;
      drv_result <= row.result;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_config(logic [1:0] fit, logic [15:0] total);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= REG_FIT_MODE;
      csr_wdata <= {14'd0, fit};
      @(posedge clock);
      csr_index <= REG_TOTAL_SIZE;
      csr_wdata <= total;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_fit = fit;
      cur_total = int'(total);
   endtask

   function automatic void add_row(logic [1:0] m, logic [15:0] id, logic [15:0] sz,
                                   bit typed, logic [2:0] st, logic [15:0] a,
                                   logic [15:0] b);
      dir_rows.push_back('{m, id, sz, typed, '{st, a, b}});
   endfunction

   function automatic stim_row_type random_row(int req_pct);
      stim_row_type row;
      int pick;
      pick = $urandom_range(99);
      row.typed = 0;
      row.result = '{RS_ALLOCATED, 16'd0, 16'd0};
      if (pick < req_pct) row.mode = OP_REQUEST;
      else if (pick < req_pct + (95 - req_pct) * 2 / 3) row.mode = OP_RELEASE;
      else if (pick < 95) row.mode = OP_FIND;
      else row.mode = OP_UNUSED;
      row.id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
      pick = $urandom_range(19);
      if (pick == 0) row.size = 16'd0;
      else if (pick == 1) row.size = 16'hFFFF;
      else if (pick < 4) row.size = 16'($urandom);
      else if (pick < 8) row.size = 16'($urandom_range(4000));
      else row.size = 16'($urandom_range(60));
      return row;
   endfunction

   initial begin
      logic [15:0] totals[8];
      int phase, n;
      stim_row_type row;
      totals = '{16'hFFFF, 16'd0, 16'd300, 16'd4000, 16'hFFFF, 16'd1, 16'd20000, 16'hFFFF};
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = OP_REQUEST;
      req_block_id = '0;
      req_request_size = '0;
      csr_we = 1'b0;
      csr_index = REG_FIT_MODE;
      csr_wdata = '0;
      drv_typed = 0;
      drv_result = '{RS_ALLOCATED, 16'd0, 16'd0};
      send_idle_pct = 0;
      recv_stall_pct = 0;
      blk_count = 0;
      rover = 0;
      cur_fit = FIT_BEST;
      cur_total = 65535;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      add_row(OP_FIND, 16'd5, 16'd0, 1, RS_NOT_FOUND, 16'd0, 16'd0);
      add_row(OP_RELEASE, 16'd5, 16'd0, 1, RS_REL_FAILED, 16'd0, 16'd0);
      add_row(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1, RS_NOT_FOUND, 16'd0, 16'd0);
      add_row(OP_REQUEST, 16'd1, 16'd0, 1, RS_ALLOCATED, 16'd0, 16'd0);
      add_row(OP_REQUEST, 16'd2, 16'hFFFF, 1, RS_ALLOCATED, 16'd0, 16'hFFFF);
      add_row(OP_REQUEST, 16'd3, 16'd1, 1, RS_REQ_FAILED, 16'd0, 16'd1);
      add_row(OP_REQUEST, 16'd4, 16'd0, 1, RS_ALLOCATED, 16'hFFFF, 16'd0);
      add_row(OP_FIND, 16'd2, 16'd0, 1, RS_FOUND, 16'd0, 16'hFFFF);
      add_row(OP_RELEASE, 16'd2, 16'd0, 1, RS_FREED, 16'd0, 16'hFFFF);
      add_row(OP_RELEASE, 16'd2, 16'd0, 1, RS_REL_FAILED, 16'd0, 16'd0);
      add_row(OP_REQUEST, 16'hFFFF, 16'd100, 0, RS_ALLOCATED, 16'd0, 16'd0);
      add_row(OP_REQUEST, 16'hFFFF, 16'd50, 0, RS_ALLOCATED, 16'd0, 16'd0);
      add_row(OP_REQUEST, 16'd0, 16'd10, 0, RS_ALLOCATED, 16'd0, 16'd0);
      add_row(OP_FIND, 16'hFFFF, 16'hFFFF, 0, RS_ALLOCATED, 16'd0, 16'd0);
      add_row(OP_RELEASE, 16'hFFFF, 16'd0, 0, RS_ALLOCATED, 16'd0, 16'd0);
      add_row(OP_FIND, 16'hFFFF, 16'd0, 0, RS_ALLOCATED, 16'd0, 16'd0);
      add_row(OP_REQUEST, 16'd7, 16'd30, 0, RS_ALLOCATED, 16'd0, 16'd0);
      add_row(OP_RELEASE, 16'd1, 16'd0, 0, RS_ALLOCATED, 16'd0, 16'd0);
      add_row(OP_RELEASE, 16'd4, 16'd0, 0, RS_ALLOCATED, 16'd0, 16'd0);
      foreach (dir_rows[i]) send_request(dir_rows[i]);
      drain_results();

      for (phase = 0; phase < 8; phase++) begin
         write_config(phase[1:0], totals[phase]);
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         for (n = 0; n < 110; n++) begin
            if (n == 55) begin
               req_valid <= 1'b0;
               while (expected_results.size() != 0) @(posedge clock);
            end
            row = random_row((n < 60) ? 70 : 40);
            send_request(row);
         end
         drain_results();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;

      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

/* files.f */
rtl/cfa_pkg.sv
rtl/cfa_ram.sv
rtl/cfa_fit.sv
rtl/contiguous_fit_allocator.sv
dv/contiguous_fit_allocator_test.sv
